### design/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the bilinear resampler
// Register indexes, field widths, the configuration and weight bundles and
// the 2x2 neighbourhood that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // Port field widths.
  localparam int PIXEL_PORT_BITS = 16;
  localparam int VALUE_BITS      = 24;
  localparam int POS_BITS        = 33;
  localparam int CFG_INDEX_BITS  = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_POSITION   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_POSITION = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_LINES       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_SAMPLES     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_LINES     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_SAMPLES   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FILL_VALUE      = 3'd6;

  // The constant 1.0 with 16 fraction bits.
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Weights are fractions of 2^32; the full weight 1.0 needs bit 32.
  localparam int WEIGHT_BITS = 33;

  // Depth of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Region geometry as the front end sees it.
  typedef struct packed {
    logic signed [16:0] line_int;      // floor of the start line
    logic signed [16:0] sample_int;    // floor of the start sample
    logic [15:0]        lines_eff;     // output lines, zero read as one
    logic [11:0]        samples_eff;   // output samples, zero read as one
    logic [15:0]        image_lines;
    logic [15:0]        image_samples;
    logic [15:0]        pad_pixel;
    logic               restart;       // a listed register written this cycle
  } geom_t;

  // The four bilinear weights.
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] w00;
    logic [WEIGHT_BITS-1:0] w01;
    logic [WEIGHT_BITS-1:0] w10;
    logic [WEIGHT_BITS-1:0] w11;
  } weights_t;

  // One 2x2 neighbourhood ready for interpolation.
  typedef struct packed {
    logic                       last;
    logic [PIXEL_PORT_BITS-1:0] above_left;
    logic [PIXEL_PORT_BITS-1:0] above;
    logic [PIXEL_PORT_BITS-1:0] left;
    logic [PIXEL_PORT_BITS-1:0] cur;
  } nbhd_t;

endpackage

### design/bsr_ifs.sv
// ----------------------------------------------------------------------------
// bsr_ifs: channel interfaces of the bilinear resampler
// Pixel input, result output and configuration write channels, each with a
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface bsr_pixel_if import bsr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [PIXEL_PORT_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bsr_result_if import bsr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bsr_cfg_if import bsr_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [POS_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bsr_config.sv
// ----------------------------------------------------------------------------
// bsr_config: configuration registers and weight generation
// Holds the region registers, presents the derived geometry to the front end
// and keeps the four bilinear weights registered for the back end.
// ----------------------------------------------------------------------------
module bsr_config
  import bsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bsr_cfg_if.sink      regs,
  output geom_t        geom,
  output weights_t     weights
);

  logic [POS_BITS-1:0] line_position;
  logic [POS_BITS-1:0] sample_position;
  logic [15:0]         out_lines;
  logic [11:0]         out_samples;
  logic [15:0]         image_lines;
  logic [15:0]         image_samples;
  logic [15:0]         pad_pixel;
  logic                wr;
  logic                known;
  logic [16:0]         inv_l;
  logic [16:0]         inv_s;
  logic [33:0]         p00;
  logic [33:0]         p01;
  logic [33:0]         p10;
  logic [33:0]         p11;

  // Writes are always taken.
  assign regs.ready = 1'b1;
  assign wr         = regs.valid && regs.ready;

  // Only the listed registers restart the window.
  always_comb begin
    known = 1'b1;
    unique case (regs.index)
      CFG_LINE_POSITION, CFG_SAMPLE_POSITION, CFG_OUT_LINES, CFG_OUT_SAMPLES,
      CFG_IMAGE_LINES, CFG_IMAGE_SAMPLES, CFG_FILL_VALUE: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position   <= '0;
      sample_position <= '0;
      out_lines       <= 16'd1;
      out_samples     <= 12'd1;
      image_lines     <= 16'd1;
      image_samples   <= 16'd1;
      pad_pixel       <= '0;
    end else if (wr) begin
      unique case (regs.index)
        CFG_LINE_POSITION:   line_position   <= regs.data;
        CFG_SAMPLE_POSITION: sample_position <= regs.data;
        CFG_OUT_LINES:       out_lines       <= regs.data[15:0];
        CFG_OUT_SAMPLES:     out_samples     <= regs.data[11:0];
        CFG_IMAGE_LINES:     image_lines     <= regs.data[15:0];
        CFG_IMAGE_SAMPLES:   image_samples   <= regs.data[15:0];
        CFG_FILL_VALUE:      pad_pixel       <= regs.data[15:0];
        default: ;
      endcase
    end
  end

  // Geometry seen by the front end; a zero size counts as one.
  always_comb begin
    geom.line_int      = $signed(line_position[32:16]);
    geom.sample_int    = $signed(sample_position[32:16]);
    geom.lines_eff     = (out_lines == '0) ? 16'd1 : out_lines;
    geom.samples_eff   = (out_samples == '0) ? 12'd1 : out_samples;
    geom.image_lines   = image_lines;
    geom.image_samples = image_samples;
    geom.pad_pixel     = pad_pixel;
    geom.restart       = wr && known;
  end

  // Weight products of the fractional parts; 1.0 times 1.0 fits 33 bits.
  assign inv_l = FRAC_ONE - {1'b0, line_position[15:0]};
  assign inv_s = FRAC_ONE - {1'b0, sample_position[15:0]};
  assign p00   = inv_l * inv_s;
  assign p01   = inv_l * {1'b0, sample_position[15:0]};
  assign p10   = {1'b0, line_position[15:0]} * inv_s;
  assign p11   = {1'b0, line_position[15:0]} * {1'b0, sample_position[15:0]};

  // The weights are registered and follow the position registers in the next cycle.
  always_ff @(posedge clk) begin
    weights.w00 <= p00[WEIGHT_BITS-1:0];
    weights.w01 <= p01[WEIGHT_BITS-1:0];
    weights.w10 <= p10[WEIGHT_BITS-1:0];
    weights.w11 <= p11[WEIGHT_BITS-1:0];
  end

endmodule

### design/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front: window walker and neighbourhood builder
// Accepts window pixels, tracks row and column, applies the fill value
// outside the image, keeps the previous row in a line store and pushes one
// 2x2 neighbourhood per interior window pixel into the queue.
// ----------------------------------------------------------------------------
module bsr_front
  import bsr_pkg::*;
#(
  parameter int MAX_WINDOW_SAMPLES = 4096,
  parameter int PIXEL_BITS         = 16
) (
  input  logic      clk,
  input  logic      rst,
  bsr_pixel_if.sink pixels,
  input  geom_t     geom,
  input  logic      q_full,
  output logic      q_push,
  output nbhd_t     q_data
);

  // Pixel width in use and line store geometry.
  localparam int PW          = (PIXEL_BITS < PIXEL_PORT_BITS) ? PIXEL_BITS
                                                              : PIXEL_PORT_BITS;
  localparam int STORE_DEPTH = (MAX_WINDOW_SAMPLES < 4096) ? MAX_WINDOW_SAMPLES
                                                           : 4096;
  localparam int AW          = $clog2(STORE_DEPTH);

  logic [15:0]        row;
  logic [15:0]        row_next;
  logic [11:0]        col;
  logic [11:0]        col_next;
  logic               accept;
  logic signed [17:0] line;
  logic signed [17:0] samp;
  logic               in_image;
  logic               col_in_store;
  logic [PW-1:0]      cur;
  logic [PW-1:0]      above;
  logic [PW-1:0]      left_pixel;
  logic [PW-1:0]      above_left_pixel;
  logic [PW-1:0]      rd_data;
  logic [PW-1:0]      row_store [STORE_DEPTH];

  assign pixels.ready = !q_full;
  assign accept       = pixels.valid && pixels.ready;

  // Pad test on the absolute position of this window pixel.
  assign line     = {geom.line_int[16], geom.line_int} + $signed({2'b00, row});
  assign samp     = {geom.sample_int[16], geom.sample_int} + $signed({6'd0, col});
  assign in_image = !line[17] && (line[16:0] < {1'b0, geom.image_lines}) &&
                    !samp[17] && (samp[16:0] < {1'b0, geom.image_samples});
  assign cur      = in_image ? pixels.pixel[PW-1:0] : geom.pad_pixel[PW-1:0];

  // Columns past the store read as zero and are not written.
  assign col_in_store = 32'(col) < MAX_WINDOW_SAMPLES;
  assign above        = col_in_store ? rd_data : '0;

  // Window counters: raster order, wrapping after the final pixel.
  always_comb begin
    row_next = row;
    col_next = col;
    if (rst || geom.restart) begin
      row_next = '0;
      col_next = '0;
    end else if (accept) begin
      if (col >= geom.samples_eff) begin
        col_next = '0;
        row_next = (row >= geom.lines_eff) ? 16'd0 : row + 16'd1;
      end else begin
        col_next = col + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
    end
  end

  // Line store: write the current column, prefetch the next one.
  always_ff @(posedge clk) begin
    if (accept && col_in_store) begin
      row_store[col[AW-1:0]] <= cur;
    end
    rd_data <= row_store[col_next[AW-1:0]];
  end

  // Left and above-left pixels of the neighbourhood.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      above_left_pixel <= '0;
    end else if (accept) begin
      left_pixel       <= cur;
      above_left_pixel <= above;
    end
  end

  // Interior pixels complete a neighbourhood.
  assign q_push            = accept && (row != '0) && (col != '0);
  assign q_data.last       = (row == geom.lines_eff) && (col == geom.samples_eff);
  assign q_data.above_left = PIXEL_PORT_BITS'(above_left_pixel);
  assign q_data.above      = PIXEL_PORT_BITS'(above);
  assign q_data.left       = PIXEL_PORT_BITS'(left_pixel);
  assign q_data.cur        = PIXEL_PORT_BITS'(cur);

endmodule

### design/bsr_queue.sv
// ----------------------------------------------------------------------------
// bsr_queue: neighbourhood queue between front end and back end
// A short register queue that lets either side stall without the other.
// ----------------------------------------------------------------------------
module bsr_queue
  import bsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  nbhd_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output nbhd_t pop_data
);

  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  nbhd_t               entries [QUEUE_DEPTH];

  assign full      = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("bsr_queue: push while full");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("bsr_queue: pop while empty");

  // The fill level stays within the depth and tracks the pointers.
  a_count_consistent: assert property (@(posedge clk) disable iff (rst)
    (count <= (QUEUE_AW+1)'(QUEUE_DEPTH)) &&
    (count[QUEUE_AW-1:0] == QUEUE_AW'(wr_ptr - rd_ptr)))
    else $error("bsr_queue: fill level inconsistent with pointers");

endmodule

### design/bsr_back.sv
// ----------------------------------------------------------------------------
// bsr_back: weighted sum and output register
// Multiplies the four neighbourhood pixels by their weights, sums, rounds to
// 8 fraction bits with saturation and holds the result for the sink.
// ----------------------------------------------------------------------------
module bsr_back
  import bsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  weights_t     weights,
  input  logic         q_valid,
  input  nbhd_t        q_data,
  output logic         q_pop,
  bsr_result_if.source results
);

  localparam int PROD_BITS = WEIGHT_BITS + PIXEL_PORT_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;

  logic                 advance;
  logic                 s1_valid;
  logic                 s1_last;
  logic [PROD_BITS-1:0] prod00;
  logic [PROD_BITS-1:0] prod01;
  logic [PROD_BITS-1:0] prod10;
  logic [PROD_BITS-1:0] prod11;
  logic [SUM_BITS-1:0]  sum;
  logic [SUM_BITS-25:0] scaled;
  logic                 s2_valid;
  logic [VALUE_BITS-1:0] s2_value;
  logic                 s2_last;

  // The whole pipeline moves when the output register can take a value.
  assign advance = !s2_valid || results.ready;
  assign q_pop   = advance && q_valid;

  // Stage one: the four products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod00  <= PROD_BITS'(weights.w00) * PROD_BITS'(q_data.above_left);
      prod01  <= PROD_BITS'(weights.w01) * PROD_BITS'(q_data.above);
      prod10  <= PROD_BITS'(weights.w10) * PROD_BITS'(q_data.left);
      prod11  <= PROD_BITS'(weights.w11) * PROD_BITS'(q_data.cur);
      s1_last <= q_data.last;
    end
  end

  // Stage two: sum, round half up, drop 24 bits and saturate.
  assign sum    = SUM_BITS'(prod00) + SUM_BITS'(prod01) + SUM_BITS'(prod10) +
                  SUM_BITS'(prod11) + (SUM_BITS'(1) << 23);
  assign scaled = sum[SUM_BITS-1:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_value <= (scaled[SUM_BITS-25:VALUE_BITS] != '0) ? {VALUE_BITS{1'b1}}
                                                         : scaled[VALUE_BITS-1:0];
      s2_last  <= s1_last;
    end
  end

  assign results.valid = s2_valid;
  assign results.value = s2_value;
  assign results.last  = s2_last;

endmodule

### design/bilinear_subpixel_resampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_subpixel_resampler_core: bilinear sub-pixel resampler
// Streams a window of pixels in raster order and emits bilinear interpolated
// pixels of a region that starts at a fractional position.
// ----------------------------------------------------------------------------
// The block takes one window pixel per clock while the neighbourhood queue
// is not full, for a window of (out_lines+1) rows by (out_samples+1)
// columns, and returns one result per window pixel that is past the first
// row and the first column, in raster order, with last set on the final
// result of the region. A result passes through the neighbourhood queue,
// which the front end fills in the cycle it takes the pixel, then the
// multiply stage of the back end, and its sum is held in the output
// register. A four entry queue between the two ends absorbs stalls on the
// result side, so the pixel channel only stalls once that queue is full.
// The line store has no clearing pass and is ready straight after reset.
// Registers must be written only while the block is idle; the block itself
// does not enforce this. Any write of a listed register restarts the window
// at its first pixel; the weights follow a new position in the next cycle.
module bilinear_subpixel_resampler_core
  import bsr_pkg::*;
#(
  parameter int MAX_WINDOW_SAMPLES = 4096,
  parameter int PIXEL_BITS         = 16
) (
  input  logic         clk,
  input  logic         rst,
  bsr_cfg_if.sink      regs,
  bsr_pixel_if.sink    pixels,
  bsr_result_if.source results
);

  geom_t    geom;
  weights_t weights;
  logic     q_full;
  logic     q_push;
  nbhd_t    q_push_data;
  logic     q_pop;
  logic     q_not_empty;
  nbhd_t    q_pop_data;

  // Configuration registers and weights.
  bsr_config u_config (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .geom    (geom),
    .weights (weights)
  );

  // Front end: window walk, padding and line store.
  bsr_front #(
    .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES),
    .PIXEL_BITS         (PIXEL_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .geom   (geom),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // Neighbourhood queue.
  bsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  // Back end: interpolation and output register.
  bsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .weights (weights),
    .q_valid (q_not_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the bilinear sub-pixel resampler
// Streams pixel windows under randomly programmed regions, predicts every
// interpolated result in the testbench and checks each result transaction
// in order against that prediction, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import bsr_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLISTED = 3'd7;
  localparam int STORE_DEPTH   = 4096;
  localparam int SMALL_ITEMS   = 1150;
  localparam int SETTLE_CYCLES = 6;
  localparam int WIDE_PIXELS   = 300;
  localparam int TALL_PIXELS   = 26;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } interp_t;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_LONG_STALL} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsr_cfg_if    cfg_ch ();
  bsr_pixel_if  pix_ch ();
  bsr_result_if res_ch ();

  bilinear_subpixel_resampler_core u_top (
    .clk     (clk),
    .rst     (rst),
    .regs    (cfg_ch),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  always #5 clk = ~clk;

  // Predicted register contents and window state.
  logic [POS_BITS-1:0]        line_pos;
  logic [POS_BITS-1:0]        samp_pos;
  logic [15:0]                out_lines_reg;
  logic [11:0]                out_samples_reg;
  logic [15:0]                img_lines;
  logic [15:0]                img_samples;
  logic [15:0]                fill_reg;
  logic [PIXEL_PORT_BITS-1:0] line_store [STORE_DEPTH];
  logic [PIXEL_PORT_BITS-1:0] left_pix;
  logic [PIXEL_PORT_BITS-1:0] above_left_pix;
  int                         win_row;
  int                         win_col;

  logic [PIXEL_PORT_BITS-1:0] pixel_queue [$];
  interp_t                    interp_queue [$];
  int                         mismatches = 0;

  // Pixel driver state: bursts of random length separated by random gaps.
  bit pix_taken  = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;

  // Works out the effect of one window pixel and queues any interpolated result.
  task automatic interpolate_step(input logic [PIXEL_PORT_BITS-1:0] pix);
    int                         nl;
    int                         ns;
    longint                     line_idx;
    longint                     samp_idx;
    bit                         in_image;
    logic [PIXEL_PORT_BITS-1:0] cur;
    logic [PIXEL_PORT_BITS-1:0] above;
    longint unsigned            one;
    longint unsigned            lf;
    longint unsigned            sf;
    longint unsigned            acc;
    longint unsigned            v;
    interp_t                    res;
    nl = (out_lines_reg == 0) ? 1 : int'(out_lines_reg);
    ns = (out_samples_reg == 0) ? 1 : int'(out_samples_reg);
    line_idx = longint'($signed(line_pos[32:16])) + longint'(win_row);
    samp_idx = longint'($signed(samp_pos[32:16])) + longint'(win_col);
    in_image = line_idx >= 0 && line_idx < longint'(img_lines) &&
               samp_idx >= 0 && samp_idx < longint'(img_samples);
    cur   = in_image ? pix : fill_reg;
    above = (win_col < STORE_DEPTH) ? line_store[win_col] : '0;
    if (win_row >= 1 && win_col >= 1) begin
      one = longint'(FRAC_ONE);
      lf  = longint'(line_pos[15:0]);
      sf  = longint'(samp_pos[15:0]);
      acc = (one - lf) * (one - sf) * longint'(above_left_pix) +
            (one - lf) * sf * longint'(above) +
            lf * (one - sf) * longint'(left_pix) +
            lf * sf * longint'(cur);
      v = (acc + (64'd1 << 23)) >> 24;
      if (v > 64'hFFFFFF) v = 64'hFFFFFF;
      res.value = v[VALUE_BITS-1:0];
      res.last  = (win_row == nl && win_col == ns);
      interp_queue.push_back(res);
    end
    if (win_col < STORE_DEPTH) line_store[win_col] = cur;
    above_left_pix = above;
    left_pix       = cur;
    if (win_col >= ns) begin
      win_col = 0;
      win_row = (win_row >= nl) ? 0 : win_row + 1;
    end else begin
      win_col = win_col + 1;
    end
  endtask

  // One register write transaction; the predicted copy follows on acceptance.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [POS_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_LINE_POSITION:   line_pos        = data;
      CFG_SAMPLE_POSITION: samp_pos        = data;
      CFG_OUT_LINES:       out_lines_reg   = data[15:0];
      CFG_OUT_SAMPLES:     out_samples_reg = data[11:0];
      CFG_IMAGE_LINES:     img_lines       = data[15:0];
      CFG_IMAGE_SAMPLES:   img_samples     = data[15:0];
      CFG_FILL_VALUE:      fill_reg        = data[15:0];
      default: ;
    endcase
    if (idx != CFG_UNLISTED) begin
      win_row = 0;
      win_col = 0;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every pixel is taken and every result has come, then lets the
  // pipeline drain, since the last pixels may have caused no result.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || pix_ch.valid || interp_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIXEL_PORT_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_PORT_BITS'($urandom);
    endcase
  endfunction

  // Register data with random bits above the field, which the block drops.
  function automatic logic [POS_BITS-1:0] padded(input logic [15:0] field, input int bits);
    logic [POS_BITS-1:0] noise;
    noise = {1'($urandom), 32'($urandom)};
    return (noise << bits) | POS_BITS'(field);
  endfunction

  // Start position around the image, now and then at the extremes.
  function automatic logic [POS_BITS-1:0] rand_position(input int img);
    int          whole;
    logic [15:0] frac;
    case ($urandom_range(0, 11))
      0: return 33'h1_0000_0000;
      1: return 33'h0_FFFF_FFFF;
      default: begin
        whole = int'($urandom_range(0, img + 4)) - 3;
        case ($urandom_range(0, 5))
          0:       frac = 16'h0000;
          1:       frac = 16'hFFFF;
          default: frac = 16'($urandom);
        endcase
        return {17'(whole), frac};
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_image_size();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic int region_length();
    int nl;
    int ns;
    nl = (out_lines_reg == 0) ? 1 : int'(out_lines_reg);
    ns = (out_samples_reg == 0) ? 1 : int'(out_samples_reg);
    return (nl + 1) * (ns + 1);
  endfunction

  // Programs a small random region; each register is rewritten most times.
  task automatic program_random_region();
    if ($urandom_range(0, 4) != 0)
      write_reg(CFG_IMAGE_LINES, padded(rand_image_size(), 16));
    if ($urandom_range(0, 4) != 0)
      write_reg(CFG_IMAGE_SAMPLES, padded(rand_image_size(), 16));
    if ($urandom_range(0, 4) != 0)
      write_reg(CFG_LINE_POSITION, rand_position(int'(img_lines)));
    if ($urandom_range(0, 4) != 0)
      write_reg(CFG_SAMPLE_POSITION, rand_position(int'(img_samples)));
    if ($urandom_range(0, 4) != 0)
      write_reg(CFG_OUT_LINES,
                padded(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5)), 16));
    if ($urandom_range(0, 4) != 0)
      write_reg(CFG_OUT_SAMPLES,
                padded(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 10)), 12));
    write_reg(CFG_FILL_VALUE, padded(rand_pixel(), 16));
  endtask

  task automatic push_random_pixels(input int count);
    repeat (count) pixel_queue.push_back(rand_pixel());
  endtask

  // Pixel side: prediction on each accepted transaction, then the result check.
  always @(posedge clk) begin : track_results
    interp_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      interpolate_step(pix_ch.pixel);
      pix_taken = 1'b1;
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (interp_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, none expected, got value %h last %b",
                 $time, res_ch.value, res_ch.last);
      end else begin
        want = interp_queue.pop_front();
        if (res_ch.value !== want.value || res_ch.last !== want.last) begin
          mismatches++;
          $display("%0t: result mismatch, expected value %h last %b, got value %h last %b",
                   $time, want.value, want.last, res_ch.value, res_ch.last);
        end
      end
    end
  end

  // Pixel driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_taken) begin
      pix_taken = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (burst_left > 0 && pixel_queue.size() > 0) begin
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= pixel_queue.pop_front();
        burst_left--;
      end else begin
        pix_ch.valid <= 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
      end
    end
  end

  // Result side: the stall pattern changes to a randomly chosen mode whenever the current mode runs out.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;
  int          stall_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS:   res_ch.ready <= 1'b1;
      RDY_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: res_ch.ready <= (mode_left % 3 != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
        end
      end
    endcase
  end

  // Stimulus: a few directed regions, then random regions with two extreme sizes slotted in.
  initial begin : stimulus
    int small_items;
    int count;
    int phase;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel    = '0;
    res_ch.ready    = 1'b0;
    line_pos        = '0;
    samp_pos        = '0;
    out_lines_reg   = 16'd1;
    out_samples_reg = 12'd1;
    img_lines       = 16'd1;
    img_samples     = 16'd1;
    fill_reg        = 16'd0;
    left_pix        = '0;
    above_left_pix  = '0;
    win_row         = 0;
    win_col         = 0;
    foreach (line_store[i]) line_store[i] = '0;
    small_items     = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a one-pixel image, the rest of the window is fill.
    pixel_queue.push_back(16'hFFFF);
    pixel_queue.push_back(16'h1234);
    pixel_queue.push_back(16'h5555);
    pixel_queue.push_back(16'hAAAA);
    wait_idle();

    // Half-pixel offsets with zero sizes, which count as one.
    write_reg(CFG_LINE_POSITION, 33'h0_0000_8000);
    write_reg(CFG_SAMPLE_POSITION, 33'h0_0000_8000);
    write_reg(CFG_OUT_LINES, 33'd0);
    write_reg(CFG_OUT_SAMPLES, 33'd0);
    write_reg(CFG_IMAGE_LINES, 33'd2);
    write_reg(CFG_IMAGE_SAMPLES, 33'd2);
    write_reg(CFG_FILL_VALUE, 33'h0_0000_FFFF);
    pixel_queue.push_back(16'h0000);
    pixel_queue.push_back(16'hFFFF);
    pixel_queue.push_back(16'hFFFF);
    pixel_queue.push_back(16'h0000);
    wait_idle();

    // Most negative line, largest sample, and an image with no lines at all.
    write_reg(CFG_LINE_POSITION, 33'h1_0000_0000);
    write_reg(CFG_SAMPLE_POSITION, 33'h0_FFFF_FFFF);
    write_reg(CFG_OUT_LINES, 33'd1);
    write_reg(CFG_OUT_SAMPLES, 33'd1);
    write_reg(CFG_IMAGE_LINES, 33'd0);
    write_reg(CFG_IMAGE_SAMPLES, 33'h0_0000_FFFF);
    write_reg(CFG_FILL_VALUE, 33'h0_0000_8001);
    push_random_pixels(4);
    wait_idle();

    // Window straddling the last image line and the left image edge.
    write_reg(CFG_LINE_POSITION, 33'h0_FFFE_FFFF);
    write_reg(CFG_SAMPLE_POSITION, 33'h1_FFFF_0001);
    write_reg(CFG_IMAGE_LINES, 33'h0_0000_FFFF);
    write_reg(CFG_FILL_VALUE, 33'h0_0000_00FF);
    pixel_queue.push_back(16'hFFFF);
    pixel_queue.push_back(16'h0001);
    pixel_queue.push_back(16'hFFFE);
    pixel_queue.push_back(16'h8000);
    wait_idle();

    // A write to the unused index, then a small region fully inside.
    write_reg(CFG_UNLISTED, 33'h1_FFFF_FFFF);
    write_reg(CFG_LINE_POSITION, 33'h0_0001_0001);
    write_reg(CFG_SAMPLE_POSITION, 33'h0_0000_FFFF);
    write_reg(CFG_OUT_SAMPLES, 33'd2);
    write_reg(CFG_IMAGE_LINES, 33'd4);
    write_reg(CFG_IMAGE_SAMPLES, 33'd4);
    push_random_pixels(6);
    wait_idle();

    // Random regions, with the widest and the tallest region slotted in.
    phase = 0;
    while (small_items < SMALL_ITEMS) begin
      if (phase == 2) begin
        // Widest region: only the start of its first row is streamed.
        write_reg(CFG_OUT_LINES, 33'd1);
        write_reg(CFG_OUT_SAMPLES, padded(16'h0FFF, 12));
        write_reg(CFG_IMAGE_LINES, 33'h0_0000_FFFF);
        write_reg(CFG_IMAGE_SAMPLES, 33'h0_0000_FFFF);
        write_reg(CFG_LINE_POSITION, {17'($urandom_range(0, 8)), 16'($urandom)});
        write_reg(CFG_SAMPLE_POSITION, {17'($urandom_range(0, 8)), 16'($urandom)});
        push_random_pixels(WIDE_PIXELS);
        small_items += WIDE_PIXELS;
        wait_idle();
        write_reg(CFG_OUT_SAMPLES, 33'd1);
      end else if (phase == 5) begin
        // Tallest region: only its first rows are streamed.
        write_reg(CFG_OUT_LINES, padded(16'hFFFF, 16));
        write_reg(CFG_OUT_SAMPLES, 33'd3);
        write_reg(CFG_IMAGE_LINES, 33'h0_0000_FFFF);
        write_reg(CFG_IMAGE_SAMPLES, 33'd6);
        push_random_pixels(TALL_PIXELS);
        small_items += TALL_PIXELS;
        wait_idle();
        write_reg(CFG_OUT_LINES, 33'd1);
      end else begin
        program_random_region();
        count = region_length();
        if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
        push_random_pixels(count);
        small_items += count;
        wait_idle();
      end
      phase++;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && interp_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #10ms;
    $display("%0t: timeout with %0d results still expected", $time, interp_queue.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
